@@ rtl/rfsp_pkg.sv @@
`timescale 1ns / 1ps

package rfsp_pkg;

    // Song memory geometry; depth is a power of two so the address is a bit slice.
    localparam int SONG_DEPTH = 4096;
    localparam int SONG_AW    = $clog2(SONG_DEPTH);

    localparam int OFFSET_W   = 13;
    localparam int LOAD_AW    = 12;
    localparam int BYTE_W     = 8;
    localparam int BUS_AW     = 16;
    localparam int NUM_SHADOW = 9;
    localparam int SHADOW_IW  = $clog2(NUM_SHADOW);
    localparam int PC_W       = 5;

    localparam logic [OFFSET_W-1:0] SONG_LENGTH_RST = 13'd4096;
    localparam logic [BUS_AW-1:0]   BUS_BASE        = 16'h8000;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Micro-operations of the tick program.
    typedef enum logic [2:0] {
        UOP_EMIT = 3'd0,   // send one shadow register to the chip, waits for output space
        UOP_RDEN = 3'd1,   // read the enable byte, bump offset
        UOP_LDEN = 3'd2,   // latch the enable byte
        UOP_TEST = 3'd3,   // enable bit set: read data byte, else jump past the load
        UOP_LDSH = 3'd4,   // latch the data byte into a shadow register
        UOP_WRAP = 3'd5    // wrap offset at song end, back to idle
    } uop_t;

    typedef struct packed {
        uop_t                 op;
        logic [SHADOW_IW-1:0] idx;
        logic [2:0]           bitsel;
        logic                 last;
        logic [PC_W-1:0]      jump;
    } ucw_t;

    function automatic ucw_t mk_ucw(uop_t op, int idx, int bitsel, bit last, int jump);
        ucw_t w;
        w.op     = op;
        w.idx    = SHADOW_IW'(idx);
        w.bitsel = 3'(bitsel);
        w.last   = last;
        w.jump   = PC_W'(jump);
        return w;
    endfunction

    // Microprogram ROM: nine writes, enable byte, then test/load pairs per register.
    function automatic ucw_t ucode_rom(logic [PC_W-1:0] pc);
        ucw_t w;
        unique case (pc)
            5'd0:    w = mk_ucw(UOP_EMIT, 2, 0, 1'b0, 0);
            5'd1:    w = mk_ucw(UOP_EMIT, 1, 0, 1'b0, 0);
            5'd2:    w = mk_ucw(UOP_EMIT, 0, 0, 1'b0, 0);
            5'd3:    w = mk_ucw(UOP_EMIT, 5, 0, 1'b0, 0);
            5'd4:    w = mk_ucw(UOP_EMIT, 4, 0, 1'b0, 0);
            5'd5:    w = mk_ucw(UOP_EMIT, 3, 0, 1'b0, 0);
            5'd6:    w = mk_ucw(UOP_EMIT, 8, 0, 1'b0, 0);
            5'd7:    w = mk_ucw(UOP_EMIT, 7, 0, 1'b0, 0);
            5'd8:    w = mk_ucw(UOP_EMIT, 6, 0, 1'b1, 0);
            5'd9:    w = mk_ucw(UOP_RDEN, 0, 0, 1'b0, 0);
            5'd10:   w = mk_ucw(UOP_LDEN, 0, 0, 1'b0, 0);
            5'd11:   w = mk_ucw(UOP_TEST, 0, 0, 1'b0, 13);
            5'd12:   w = mk_ucw(UOP_LDSH, 0, 0, 1'b0, 0);
            5'd13:   w = mk_ucw(UOP_TEST, 1, 1, 1'b0, 15);
            5'd14:   w = mk_ucw(UOP_LDSH, 1, 0, 1'b0, 0);
            5'd15:   w = mk_ucw(UOP_TEST, 2, 2, 1'b0, 17);
            5'd16:   w = mk_ucw(UOP_LDSH, 2, 0, 1'b0, 0);
            5'd17:   w = mk_ucw(UOP_TEST, 3, 3, 1'b0, 19);
            5'd18:   w = mk_ucw(UOP_LDSH, 3, 0, 1'b0, 0);
            5'd19:   w = mk_ucw(UOP_TEST, 4, 4, 1'b0, 21);
            5'd20:   w = mk_ucw(UOP_LDSH, 4, 0, 1'b0, 0);
            5'd21:   w = mk_ucw(UOP_TEST, 5, 5, 1'b0, 23);
            5'd22:   w = mk_ucw(UOP_LDSH, 5, 0, 1'b0, 0);
            5'd23:   w = mk_ucw(UOP_TEST, 6, 6, 1'b0, 25);
            5'd24:   w = mk_ucw(UOP_LDSH, 6, 0, 1'b0, 0);
            5'd25:   w = mk_ucw(UOP_TEST, 7, 7, 1'b0, 27);
            5'd26:   w = mk_ucw(UOP_LDSH, 7, 0, 1'b0, 0);
            // register 8 shares enable bit 7 with register 7
            5'd27:   w = mk_ucw(UOP_TEST, 8, 7, 1'b0, 29);
            5'd28:   w = mk_ucw(UOP_LDSH, 8, 0, 1'b0, 0);
            default: w = mk_ucw(UOP_WRAP, 0, 0, 1'b0, 0);
        endcase
        return w;
    endfunction

    // Chip address for shadow register idx = 3*(channel-1) + register, channels 1..3.
    function automatic logic [BUS_AW-1:0] bus_addr_of(logic [SHADOW_IW-1:0] idx);
        logic [1:0] ch;
        logic [1:0] rg;
        if (idx < SHADOW_IW'(3)) begin
            ch = 2'd1;
            rg = 2'(idx);
        end else if (idx < SHADOW_IW'(6)) begin
            ch = 2'd2;
            rg = 2'(idx - SHADOW_IW'(3));
        end else begin
            ch = 2'd3;
            rg = 2'(idx - SHADOW_IW'(6));
        end
        return BUS_BASE | {2'b00, ch, 12'h000} | {14'h0000, rg};
    endfunction

endpackage

@@ rtl/register_frame_song_player.sv @@
`timescale 1ns / 1ps

// Register-frame song player. Load items (s_tuser = 1) write one byte into a
// 4096-byte song memory and are accepted whenever no tick runs. A tick item
// (s_tuser = 0) first replays the nine shadow registers as nine chip writes on
// the m_ side (channels 1..3, registers 2..0 within a channel, m_tlast on the
// ninth), then decodes one frame from the song: an enable byte and one data
// byte per shadow register whose enable bit is set (registers 7 and 8 share
// bit 7). After the frame the read offset returns to zero once it is at or past
// song_length. A tick is run by a small microprogram, one control word per
// cycle unless a write stalls on the m_ side: the nine writes, a read and a
// latch for the enable byte, a test and, for a set bit, a load per shadow
// register (one memory read port, registered reads), and a wrap to finish.
// s_tready and cfg_ready are low while a tick runs, so song_length is only
// written while idle. The song memory is not cleared at reset.
module register_frame_song_player
    import rfsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // load_addr[11:0], load_data[19:12], zero pad
    input  logic                  s_tuser,   // req_type

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // bus_addr[15:0], bus_data[23:16]
    output logic                  m_tlast,   // last_write

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OFFSET_W-1:0]   cfg_data   // song_length
);

    logic                  busy_reg;
    logic [PC_W-1:0]       pc_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [OFFSET_W-1:0]   length_reg;
    logic [BYTE_W-1:0]     en_reg;
    logic [BYTE_W-1:0]     rd_data_reg;
    logic [BYTE_W-1:0]     shadow_reg [NUM_SHADOW];
    logic [BYTE_W-1:0]     song_mem [SONG_DEPTH];

    logic                  m_tvalid_reg;
    logic [BUS_AW-1:0]     m_addr_reg;
    logic [BYTE_W-1:0]     m_data_reg;
    logic                  m_tlast_reg;

    ucw_t                  uw;
    logic                  out_free;
    logic                  step_go;
    logic                  s_fire;

    assign uw       = ucode_rom(pc_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    // only a write step can stall, and only on a full output register
    assign step_go  = busy_reg && !((uw.op == UOP_EMIT) && !out_free);
    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;

    assign cfg_ready = !busy_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_data_reg, m_addr_reg};
    assign m_tlast  = m_tlast_reg;

    // Song memory: writes from load items while idle, registered reads while busy.
    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser) begin
            song_mem[s_tdata[SONG_AW-1:0]] <= s_tdata[LOAD_AW +: BYTE_W];
        end
        if (busy_reg) begin
            rd_data_reg <= song_mem[offset_reg[SONG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= SONG_LENGTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            length_reg <= cfg_data;
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pc_reg       <= '0;
            offset_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_SHADOW; i++) begin
                shadow_reg[i] <= '0;
            end
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_fire && !s_tuser) begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end

            if (step_go) begin
                unique case (uw.op)
                    UOP_EMIT: begin
                        m_tvalid_reg <= 1'b1;
                        m_addr_reg   <= bus_addr_of(uw.idx);
                        m_data_reg   <= shadow_reg[uw.idx];
                        m_tlast_reg  <= uw.last;
                        pc_reg       <= pc_reg + 1'b1;
                    end
                    UOP_RDEN: begin
                        offset_reg <= offset_reg + 1'b1;
                        pc_reg     <= pc_reg + 1'b1;
                    end
                    UOP_LDEN: begin
                        en_reg <= rd_data_reg;
                        pc_reg <= pc_reg + 1'b1;
                    end
                    UOP_TEST: begin
                        if (en_reg[uw.bitsel]) begin
                            offset_reg <= offset_reg + 1'b1;
                            pc_reg     <= pc_reg + 1'b1;
                        end else begin
                            pc_reg <= uw.jump;
                        end
                    end
                    UOP_LDSH: begin
                        shadow_reg[uw.idx] <= rd_data_reg;
                        pc_reg             <= pc_reg + 1'b1;
                    end
                    UOP_WRAP: begin
                        if (offset_reg >= length_reg) begin
                            offset_reg <= '0;
                        end
                        busy_reg <= 1'b0;
                    end
                    default: begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

endmodule
